// ===== sv/fvno_pkg.sv =====
// ----------------------------------------------------------------------------
// fvno_pkg
// Shared constants, types and helpers for the frame value-noise offset block.
// ----------------------------------------------------------------------------
package fvno_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_LANES     = 7;
	localparam int NUM_CH        = 5;
	localparam int AMT_W         = 17;
	localparam int SPAN_W        = 8;

	localparam logic [AMT_W-1:0] AMT_ONE    = 17'd65536;
	localparam logic [6:0]       PERIOD_MIN = 7'd1;
	localparam logic [6:0]       PERIOD_MAX = 7'd120;
	localparam logic [6:0]       PERIOD_RST = 7'd24;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_AMOUNT = 2'd0,
		REG_PERIOD = 2'd1,
		REG_SEED   = 2'd2
	} reg_idx_t;

	// hash constants
	localparam logic [31:0] HASH_GOLD = 32'h9e3779b1;
	localparam logic [31:0] MIX_C1    = 32'h7feb352d;
	localparam logic [31:0] MIX_C2    = 32'h846ca68b;

	// per-lane salts: primary, secondary, then the five detail lanes
	localparam logic [31:0] LANE_SALT [NUM_LANES] = '{
		32'h4f1bbcdc, 32'ha511e9b3, 32'h73a82f1d, 32'h9e2c6b6f,
		32'h27d4eb2f, 32'h165667b1, 32'hb5297a4d
	};

	// detail span round(p*n/d): numerator, half divisor, reciprocal of d in Q16
	localparam int DET_MUL   [NUM_CH] = '{3, 5, 7, 11, 13};
	localparam int DET_HALF  [NUM_CH] = '{2, 3, 5, 10, 10};
	localparam int DET_RECIP [NUM_CH] = '{16384, 10923, 6554, 3277, 3277};

	// Q16 mix weights and channel limits
	localparam int W_CARRIER = 51118;
	localparam int CH_WEIGHT [NUM_CH] = '{57672, 49807, 31457, 27525, 36045};
	localparam int CH_LIMIT  [NUM_CH] = '{39322, 13107, 15729, 15729, 15729};

	// one queued item: frame, per-lane spans and the clamped amount
	typedef struct packed {
		logic [63:0]                       frame;
		logic [NUM_LANES-1:0][SPAN_W-1:0]  span;
		logic [AMT_W-1:0]                  amt;
	} item_t;

	// round(p*n/d) with a minimum of one, division by reciprocal multiply
	function automatic logic [SPAN_W-1:0] scaled_span(input logic [6:0] p, input int n,
			input int half, input int recip);
		logic [10:0] x;
		logic [26:0] pr;
		logic [SPAN_W-1:0] r;
		x  = 11'(p) * 11'(n) + 11'(half);
		pr = 27'(x) * 27'(recip);
		r  = SPAN_W'(pr >> 16);
		if (r == '0) begin
			r = SPAN_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== sv/fvno_fifo.sv =====
// ----------------------------------------------------------------------------
// fvno_fifo
// Small register queue with a valid/ready push side and a valid/ready pop side.
// ----------------------------------------------------------------------------
module fvno_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ===== sv/fvno_lane.sv =====
// ----------------------------------------------------------------------------
// fvno_lane
// One value-noise lane: floor division by the span, lattice hashing of two
// neighbors, smootherstep and the blend, all as a fixed-latency pipeline.
// ----------------------------------------------------------------------------
module fvno_lane import fvno_pkg::*; #(
	parameter int          FRAC_BITS = FRAC_BITS_DEF,
	parameter logic [31:0] SALT      = 32'h0
) (
	input  logic                        clk,
	input  logic [63:0]                 frame,
	input  logic [SPAN_W-1:0]           span,
	input  logic [31:0]                 seed,
	output logic signed [FRAC_BITS:0]   noise
);

	localparam int F   = FRAC_BITS;
	localparam int NS  = (64 + F + 7) / 8;
	localparam int W   = NS * 8;
	localparam int XW  = F + 1;
	localparam int PW  = 2 * F + 2;
	localparam int SPW = F + 6;
	localparam int DW  = F + 2;
	localparam int PRW = 2 * F + 4;
	localparam logic [XW-1:0] ONE_X = XW'(1) << F;

	// eight quotient bits per stage of restoring division
	function automatic logic [W+7:0] div8(input logic [W-1:0] d_in, input logic [7:0] r_in,
			input logic [7:0] sp);
		logic [W-1:0] d;
		logic [8:0]   r2;
		logic [7:0]   r;
		d = d_in;
		r = r_in;
		for (int i = 0; i < 8; i++) begin
			r2 = {r, d[W-1]};
			d  = {d[W-2:0], 1'b0};
			if (r2 >= {1'b0, sp}) begin
				r2   = r2 - {1'b0, sp};
				d[0] = 1'b1;
			end
			r = r2[7:0];
		end
		return {d, r};
	endfunction

	// fractional product, value stays within one
	function automatic logic [XW-1:0] mulf(input logic [XW-1:0] a, input logic [XW-1:0] b);
		logic [PW-1:0] p;
		p = PW'(a) * PW'(b);
		return p[2*F:F];
	endfunction

	function automatic logic [31:0] hash_a(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] sd);
		logic [31:0] v;
		v = sd ^ SALT ^ lo ^ hi;
		v = v ^ (v >> 16);
		return v * MIX_C1;
	endfunction

	// magnitude of the frame
	logic [63:0]       mag_q;
	logic [SPAN_W-1:0] sp0_q;
	logic              neg0_q;

	always_ff @(posedge clk) begin
		mag_q  <= frame[63] ? (~frame + 64'd1) : frame;
		sp0_q  <= span;
		neg0_q <= frame[63];
	end

	// division pipeline over magnitude * 2^F
	logic [W-1:0]      dv_q  [NS];
	logic [7:0]        rm_q  [NS];
	logic [SPAN_W-1:0] sp_q  [NS];
	logic              neg_q [NS];

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic [W-1:0]      d_in;
		logic [7:0]        r_in;
		logic [SPAN_W-1:0] sp_in;
		logic              ng_in;
		if (k == 0) begin : g_first
			assign d_in  = W'(mag_q) << F;
			assign r_in  = '0;
			assign sp_in = sp0_q;
			assign ng_in = neg0_q;
		end else begin : g_next
			assign d_in  = dv_q[k-1];
			assign r_in  = rm_q[k-1];
			assign sp_in = sp_q[k-1];
			assign ng_in = neg_q[k-1];
		end
		always_ff @(posedge clk) begin
			{dv_q[k], rm_q[k]} <= div8(d_in, r_in, sp_in);
			sp_q[k]            <= sp_in;
			neg_q[k]           <= ng_in;
		end
	end

	// floor correction for negative frames
	logic [63:0]   qint;
	logic [F-1:0]  fm;
	logic [63:0]   lat;
	logic [XW-1:0] frac;
	logic [63:0]   lat_s1;
	logic [XW-1:0] frac_s1;

	assign qint = dv_q[NS-1][F+63:F];
	assign fm   = dv_q[NS-1][F-1:0];

	always_comb begin
		if (!neg_q[NS-1]) begin
			lat  = qint;
			frac = XW'(fm);
		end else if (fm == '0) begin
			lat  = ~qint + 64'd1;
			frac = '0;
		end else begin
			lat  = ~qint;
			frac = ONE_X - XW'(fm) - XW'(rm_q[NS-1] != '0);
		end
	end

	always_ff @(posedge clk) begin
		lat_s1  <= lat;
		frac_s1 <= frac;
	end

	// neighbor lattice point, start of the power chain
	logic [63:0]   lata_s2, latb_s2;
	logic [XW-1:0] x_s2, x2_s2;

	always_ff @(posedge clk) begin
		lata_s2 <= lat_s1;
		latb_s2 <= lat_s1 + 64'd1;
		x_s2    <= frac_s1;
		x2_s2   <= mulf(frac_s1, frac_s1);
	end

	// high word fold
	logic [31:0]   ha_s3, hb_s3, loa_s3, lob_s3;
	logic [XW-1:0] x_s3, x3_s3;

	always_ff @(posedge clk) begin
		ha_s3  <= lata_s2[63:32] * HASH_GOLD;
		hb_s3  <= latb_s2[63:32] * HASH_GOLD;
		loa_s3 <= lata_s2[31:0];
		lob_s3 <= latb_s2[31:0];
		x_s3   <= x_s2;
		x3_s3  <= mulf(x2_s2, x_s2);
	end

	// first mixing multiply
	logic [31:0]   ma_s4, mb_s4;
	logic [XW-1:0] x_s4, x3_s4, x4_s4;

	always_ff @(posedge clk) begin
		ma_s4 <= hash_a(loa_s3, ha_s3, seed);
		mb_s4 <= hash_a(lob_s3, hb_s3, seed);
		x_s4  <= x_s3;
		x3_s4 <= x3_s3;
		x4_s4 <= mulf(x3_s3, x_s3);
	end

	// second mixing multiply
	logic [31:0]   ma_s5, mb_s5;
	logic [XW-1:0] x3_s5, x4_s5, x5_s5;

	always_ff @(posedge clk) begin
		ma_s5 <= (ma_s4 ^ (ma_s4 >> 15)) * MIX_C2;
		mb_s5 <= (mb_s4 ^ (mb_s4 >> 15)) * MIX_C2;
		x3_s5 <= x3_s4;
		x4_s5 <= x4_s4;
		x5_s5 <= mulf(x4_s4, x_s4);
	end

	// lattice values and smootherstep weight
	logic [31:0]           fa, fb;
	logic signed [SPW-1:0] poly;
	logic [XW-1:0]         s_c;
	logic signed [XW-1:0]  va_s6, vb_s6;
	logic [XW-1:0]         s_s6;

	assign fa = ma_s5 ^ (ma_s5 >> 16);
	assign fb = mb_s5 ^ (mb_s5 >> 16);

	always_comb begin
		poly = SPW'(6) * signed'(SPW'(x5_s5)) - SPW'(15) * signed'(SPW'(x4_s5))
			+ SPW'(10) * signed'(SPW'(x3_s5));
		if (poly < 0) begin
			s_c = '0;
		end else if (poly > signed'(SPW'(ONE_X))) begin
			s_c = ONE_X;
		end else begin
			s_c = XW'(poly);
		end
	end

	always_ff @(posedge clk) begin
		va_s6 <= signed'(fa[31:31-F] - ONE_X);
		vb_s6 <= signed'(fb[31:31-F] - ONE_X);
		s_s6  <= s_c;
	end

	// difference times weight
	logic signed [DW-1:0]  diff;
	logic signed [PRW-1:0] prod_s7;
	logic signed [XW-1:0]  va_s7;

	assign diff = DW'(vb_s6) - DW'(va_s6);

	always_ff @(posedge clk) begin
		prod_s7 <= PRW'(diff) * signed'(PRW'(s_s6));
		va_s7   <= va_s6;
	end

	// blend result
	logic signed [DW-1:0] nsum;
	logic signed [XW-1:0] noise_s8;

	assign nsum = DW'(va_s7) + DW'(prod_s7 >>> F);

	always_ff @(posedge clk) begin
		noise_s8 <= XW'(nsum);
	end

	assign noise = noise_s8;

endmodule

// ===== sv/fvno_front.sv =====
// ----------------------------------------------------------------------------
// fvno_front
// Configuration registers and input acceptance; derives the lane spans and
// the clamped amount for each frame and pushes it into the work queue.
// ----------------------------------------------------------------------------
module fvno_front import fvno_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	output logic        push_valid,
	input  logic        push_ready,
	output item_t       push_item,
	output logic [31:0] seed
);

	logic [AMT_W-1:0] amount_q;
	logic [6:0]       period_q;
	logic [31:0]      seed_q;
	logic [6:0]       p;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= '0;
			period_q <= PERIOD_RST;
			seed_q   <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_AMOUNT: amount_q <= cfg_data[AMT_W-1:0];
				REG_PERIOD: period_q <= cfg_data[6:0];
				REG_SEED:   seed_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// period limited to its legal range
	always_comb begin
		if (period_q < PERIOD_MIN) begin
			p = PERIOD_MIN;
		end else if (period_q > PERIOD_MAX) begin
			p = PERIOD_MAX;
		end else begin
			p = period_q;
		end
	end

	// item assembly
	always_comb begin
		push_item.frame   = s_axis_tdata;
		push_item.amt     = (amount_q > AMT_ONE) ? AMT_ONE : amount_q;
		push_item.span[0] = SPAN_W'(p);
		push_item.span[1] = {p, 1'b0};
		for (int i = 0; i < NUM_CH; i++) begin
			push_item.span[i+2] = scaled_span(p, DET_MUL[i], DET_HALF[i], DET_RECIP[i]);
		end
	end

	assign push_valid    = s_axis_tvalid;
	assign s_axis_tready = push_ready;
	assign seed          = seed_q;

endmodule

// ===== sv/fvno_back.sv =====
// ----------------------------------------------------------------------------
// fvno_back
// Lane pipelines, carrier and channel mixes, scaling and the output queue.
// Items enter only while the output queue has a slot reserved for them.
// ----------------------------------------------------------------------------
module fvno_back import fvno_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	input  logic [31:0] seed,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata
);

	localparam int F         = FRAC_BITS;
	localparam int NS        = (64 + F + 7) / 8;
	localparam int LANE_LAT  = NS + 9;
	localparam int BL        = LANE_LAT + 6;
	localparam int OUT_DEPTH = 1 << $clog2(BL + 2);
	localparam int CW        = $clog2(OUT_DEPTH) + 1;
	localparam int MW        = F + 2;
	localparam int SW        = F + 20;
	localparam int TW        = F + 19;
	localparam int PHW       = F + 21;
	localparam int VW        = F + 40;
	localparam logic signed [SW-1:0] ONE_W = SW'(1) <<< F;
	localparam logic signed [VW-1:0] RND   = VW'(1) <<< (F + 16);

	function automatic logic signed [MW-1:0] blend(input logic signed [MW-1:0] c,
			input logic signed [MW-1:0] d, input int w);
		logic signed [SW-1:0] sum;
		logic signed [SW-1:0] sh;
		logic signed [MW-1:0] r;
		sum = SW'(c) * SW'(w) + SW'(d) * SW'(65536 - w);
		sh  = sum >>> 16;
		if (sh > ONE_W) begin
			r = MW'(ONE_W);
		end else if (sh < -ONE_W) begin
			r = MW'(-ONE_W);
		end else begin
			r = MW'(sh);
		end
		return r;
	endfunction

	// credit: items in flight plus items waiting at the output
	logic          issue;
	logic          pop;
	logic [CW-1:0] cnt_q;

	assign q_ready = (cnt_q < CW'(OUT_DEPTH));
	assign issue   = q_valid && q_ready;
	assign pop     = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(issue) - CW'(pop);
		end
	end

	// valid and amount travel beside the pipeline
	logic             vld_q [BL];
	logic [AMT_W-1:0] amt_q [LANE_LAT+3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < BL; j++) begin
				vld_q[j] <= 1'b0;
			end
		end else begin
			vld_q[0] <= issue;
			for (int j = 1; j < BL; j++) begin
				vld_q[j] <= vld_q[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		amt_q[0] <= q_item.amt;
		for (int j = 1; j < LANE_LAT + 3; j++) begin
			amt_q[j] <= amt_q[j-1];
		end
	end

	// noise lanes
	logic signed [F:0] noise [NUM_LANES];

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		fvno_lane #(
			.FRAC_BITS (FRAC_BITS),
			.SALT      (LANE_SALT[i])
		) u_lane (
			.clk   (clk),
			.frame (q_item.frame),
			.span  (q_item.span[i]),
			.seed  (seed),
			.noise (noise[i])
		);
	end

	// carrier from primary and secondary lanes
	logic signed [MW-1:0] car_s1;
	logic signed [MW-1:0] det_s1 [NUM_CH];

	always_ff @(posedge clk) begin
		car_s1 <= blend(MW'(noise[0]), MW'(noise[1]), W_CARRIER);
		for (int i = 0; i < NUM_CH; i++) begin
			det_s1[i] <= MW'(noise[i+2]);
		end
	end

	// channel mixes
	logic signed [MW-1:0] mix_s2 [NUM_CH];

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			mix_s2[i] <= blend(car_s1, det_s1[i], CH_WEIGHT[i]);
		end
	end

	// channel limit
	logic signed [TW-1:0] t_s3 [NUM_CH];

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			t_s3[i] <= TW'(mix_s2[i]) * TW'(CH_LIMIT[i]);
		end
	end

	// amount, as two partial products
	logic [32:0]           plo_s4 [NUM_CH];
	logic signed [PHW-1:0] phi_s4 [NUM_CH];

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			plo_s4[i] <= 33'(t_s3[i][15:0]) * 33'(amt_q[LANE_LAT+2]);
			phi_s4[i] <= PHW'(t_s3[i] >>> 16) * signed'(PHW'(amt_q[LANE_LAT+2]));
		end
	end

	// partial product sum
	logic signed [VW-1:0] v_s5 [NUM_CH];

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			v_s5[i] <= (VW'(phi_s4[i]) <<< 16) + signed'(VW'(plo_s4[i]));
		end
	end

	// round half up to Q1.15
	logic signed [VW-1:0] rnd [NUM_CH];
	logic [15:0]          out_s6 [NUM_CH];

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			rnd[i] = (v_s5[i] + RND) >>> (F + 17);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_CH; i++) begin
			out_s6[i] <= rnd[i][15:0];
		end
	end

	// output queue
	logic        out_wr_ready;
	logic [79:0] out_data;

	assign out_data = {out_s6[4], out_s6[3], out_s6[2], out_s6[1], out_s6[0]};

	fvno_fifo #(
		.WIDTH (80),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (vld_q[BL-1]),
		.wr_ready (out_wr_ready),
		.wr_data  (out_data),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_data  (m_axis_tdata)
	);

	// credit never exceeds the queue depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(OUT_DEPTH))
		else $error("credit count above output queue depth");

	// a finished result always finds room
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[BL-1] |-> out_wr_ready)
		else $error("result written into a full output queue");

	// no result shows without an item in flight
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !m_axis_tvalid)
		else $error("result present with no credit in use");

	// an issue always takes a credit
	a_issue_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && !pop && cnt_q != CW'(OUT_DEPTH)) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("credit not taken on issue");

endmodule

// ===== sv/frame_value_noise_offsets.sv =====
// ----------------------------------------------------------------------------
// frame_value_noise_offsets
// Maps a signed frame index to five hashed value-noise offsets (exposure,
// contrast, cyan, magenta, yellow) in Q1.15.
//
//   channel   dir  transfer                 payload
//   s_axis    in   tvalid & tready          frame_number
//   m_axis    out  tvalid & tready          five offsets
//   cfg       in   cfg_we                   amount, period_frames, noise_seed
//
// One frame per cycle sustained while the work queue has room. Each lane holds
// an eight-bit-per-stage span divider followed by the hash and mix stages.
// Reset clears the queues and the credit count; registers take their defaults.
// Input stalls when the work queue fills, once all output queue credits are in use.
// ----------------------------------------------------------------------------
module frame_value_noise_offsets import fvno_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] frame_number
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata    // [15:0] exposure_offset, [31:16] contrast_offset,
	                                    // [47:32] cyan_offset, [63:48] magenta_offset,
	                                    // [79:64] yellow_offset
);

	logic        push_valid;
	logic        push_ready;
	item_t       push_item;
	logic        q_valid;
	logic        q_ready;
	item_t       q_item;
	logic [31:0] seed;

	// front: config and item setup
	fvno_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item),
		.seed          (seed)
	);

	// work queue between front and back
	fvno_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_item)
	);

	// back: lanes, mixing and output
	fvno_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item),
		.seed          (seed),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for frame_value_noise_offsets: frames are streamed in
// with random valid/ready gaps, a local noise predictor computes the five
// offsets for each accepted frame and the output transfers are compared in
// order. Configuration changes only while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_top import fvno_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB      = 16;
	localparam int LATENCY = 40;
	localparam int WD_MAX  = 5000;

	typedef struct packed {
		logic signed [15:0] yel;
		logic signed [15:0] mag;
		logic signed [15:0] cyn;
		logic signed [15:0] con;
		logic signed [15:0] exp_o;
	} offsets_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [79:0] m_axis_tdata;

	frame_value_noise_offsets DUT (.*);

	always #5 clk = ~clk;

	// predictor copy of the registers
	logic [16:0] amt_reg = 17'd0;
	logic [6:0]  per_reg = PERIOD_RST;
	logic [31:0] seed_reg = '0;

	logic [63:0] frame_q[$];
	offsets_t    offsets_q[$];
	int          errors = 0;
	bit          idle_en = 0;
	int          wd = 0;

	function automatic longint fshift(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic longint hval(logic [63:0] lat, logic [31:0] salt);
		logic [31:0] v;
		v = seed_reg ^ salt ^ lat[31:0];
		v ^= lat[63:32] * HASH_GOLD;
		v ^= v >> 16;
		v *= MIX_C1;
		v ^= v >> 15;
		v *= MIX_C2;
		v ^= v >> 16;
		return longint'(v >> (31 - FB)) - (64'sd1 << FB);
	endfunction

	function automatic longint smooth(longint x);
		longint x2, x3, x4, x5, s;
		if (x > (1 << FB)) x = 1 << FB;
		x2 = (x * x) >> FB;
		x3 = (x2 * x) >> FB;
		x4 = (x3 * x) >> FB;
		x5 = (x4 * x) >> FB;
		s = 6 * x5 - 15 * x4 + 10 * x3;
		if (s < 0) s = 0;
		if (s > (1 << FB)) s = 1 << FB;
		return s;
	endfunction

	function automatic longint lane_noise(logic [63:0] f, longint span, logic [31:0] salt);
		logic [63:0] lat, rem, m, q, r, sp;
		longint a, b;
		sp = span;
		if (!f[63]) begin
			lat = f / sp;
			rem = f % sp;
		end else begin
			m = ~f + 64'd1;
			q = m / sp;
			r = m % sp;
			if (r == 0) begin
				lat = -q;
				rem = 0;
			end else begin
				lat = -(q + 64'd1);
				rem = sp - r;
			end
		end
		a = hval(lat, salt);
		b = hval(lat + 64'd1, salt);
		return a + fshift((b - a) * smooth(longint'((rem << FB) / sp)), FB);
	endfunction

	function automatic longint unit_clamp(longint v);
		if (v > (1 << FB)) return 1 << FB;
		if (v < -(1 << FB)) return -(1 << FB);
		return v;
	endfunction

	function automatic offsets_t predict_offsets(logic [63:0] f);
		offsets_t o;
		longint p, amt, car, mx, sp, v;
		logic [15:0] ch [NUM_CH];
		o = '0;
		if (amt_reg == 0) return o;
		amt = amt_reg > 17'd65536 ? 65536 : amt_reg;
		p = per_reg < 1 ? 1 : (per_reg > 120 ? 120 : per_reg);
		car = unit_clamp(fshift(lane_noise(f, p, LANE_SALT[0]) * W_CARRIER
			+ lane_noise(f, 2 * p, LANE_SALT[1]) * (65536 - W_CARRIER), 16));
		for (int i = 0; i < NUM_CH; i++) begin
			sp = (p * DET_MUL[i] + DET_HALF[i]) / (2 * DET_HALF[i] + (i == 1 ? 0 : 0));
			case (i)
				0: sp = (p * 3 + 2) / 4;
				1: sp = (p * 5 + 3) / 6;
				2: sp = (p * 7 + 5) / 10;
				default: sp = (p * DET_MUL[i] + 10) / 20;
			endcase
			if (sp < 1) sp = 1;
			mx = unit_clamp(fshift(car * CH_WEIGHT[i]
				+ lane_noise(f, sp, LANE_SALT[i+2]) * (65536 - CH_WEIGHT[i]), 16));
			v = mx * CH_LIMIT[i] * amt;
			ch[i] = 16'(fshift(v + (64'sd1 << (FB + 16)), FB + 17));
		end
		o.exp_o = ch[0];
		o.con = ch[1];
		o.cyn = ch[2];
		o.mag = ch[3];
		o.yel = ch[4];
		return o;
	endfunction

	// driver: source transfers with random gaps
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			offsets_q.push_back(predict_offsets(s_axis_tdata));
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (frame_q.size() > 0 && !(idle_en && $urandom_range(99) < 25)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= frame_q.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: sink stalls and result checking
	always @(posedge clk) begin
		if (arst_n) begin
			m_axis_tready <= !(idle_en && $urandom_range(99) < 25);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			offsets_t got, want;
			got = m_axis_tdata;
			if (offsets_q.size() == 0) begin
				$error("unexpected result transfer %h", m_axis_tdata);
				errors++;
			end else begin
				want = offsets_q.pop_front();
				if (got.exp_o !== want.exp_o) begin
					$error("exposure_offset exp %h got %h", want.exp_o, got.exp_o); errors++;
				end
				if (got.con !== want.con) begin
					$error("contrast_offset exp %h got %h", want.con, got.con); errors++;
				end
				if (got.cyn !== want.cyn) begin
					$error("cyan_offset exp %h got %h", want.cyn, got.cyn); errors++;
				end
				if (got.mag !== want.mag) begin
					$error("magenta_offset exp %h got %h", want.mag, got.mag); errors++;
				end
				if (got.yel !== want.yel) begin
					$error("yellow_offset exp %h got %h", want.yel, got.yel); errors++;
				end
			end
		end
	end

	// watchdog on stalled progress
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (frame_q.size() == 0 && offsets_q.size() == 0 && !s_axis_tvalid))
			wd <= 0;
		else
			wd <= wd + 1;
		if (wd >= WD_MAX) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_AMOUNT: amt_reg = val[16:0];
			REG_PERIOD: per_reg = val[6:0];
			REG_SEED:   seed_reg = val;
			default: ;
		endcase
	endtask

	task automatic drain;
		while (frame_q.size() > 0 || s_axis_tvalid || offsets_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_frame();
		logic [63:0] f;
		f = {$urandom, $urandom};
		case ($urandom_range(3))
			0: f = 64'($signed(32'($urandom_range(2000)) - 32'sd1000));
			1: f = 64'($urandom_range(100000));
			default: ;
		endcase
		return f;
	endfunction

	initial begin
		static logic [16:0] amts[6] = '{17'd0, 17'd1, 17'd65536, 17'd131071, 17'd32768,
			17'd70000};
		static logic [6:0]  pers[6] = '{7'd24, 7'd0, 7'd127, 7'd1, 7'd120, 7'd2};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset defaults first: amount zero gives zero outputs
		frame_q.push_back(64'd5);
		drain();
		write_reg(REG_AMOUNT, 32'd65536);
		write_reg(REG_SEED, 32'hFFFF_FFFF);
		// directed: extremes, negatives, lattice boundaries, wraparound
		frame_q.push_back(64'd0);
		frame_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
		frame_q.push_back(64'h7FFF_FFFF_FFFF_FFFF);
		frame_q.push_back(64'h8000_0000_0000_0000);
		frame_q.push_back(64'd24);
		frame_q.push_back(-64'd24);
		frame_q.push_back(-64'd25);
		frame_q.push_back(64'd23);
		frame_q.push_back(64'hAAAA_AAAA_5555_5555);
		frame_q.push_back(64'h5555_5555_AAAA_AAAA);
		frame_q.push_back(64'hFFFF_FFFF_0000_0000);
		drain();
		// ignored write to an unused index
		write_reg(reg_idx_t'(2'd3), 32'h1234_5678);
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_AMOUNT, 32'(amts[ph]));
			write_reg(REG_PERIOD, 32'(pers[ph]));
			write_reg(REG_SEED, (ph == 0) ? 32'd0 : $urandom);
			idle_en = (ph != 2);
			frame_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
			frame_q.push_back(64'h7FFF_FFFF_FFFF_FFFF);
			for (int n = 0; n < 250; n++)
				frame_q.push_back(rand_frame());
			drain();
		end
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
